[design/q6k_quantized_dot_product_assert.svh]
// Assertion macros for the Q6_K dot-product block.
`ifndef Q6K_QUANTIZED_DOT_PRODUCT_ASSERT_SVH
`define Q6K_QUANTIZED_DOT_PRODUCT_ASSERT_SVH
`ifndef SYNTHESIS
`define Q6K_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define Q6K_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define Q6K_ASSERT_IMP(lbl, a, c, msg)
`define Q6K_ASSERT_NXT(lbl, a, c, msg)
`endif
`endif

[design/q6k_pkg.sv]
// Shared types and constants for the Q6_K dot-product block.
package q6k_pkg;

  localparam int LANES     = 4;
  localparam int NIB_W     = 4;
  localparam int HIBITS_W  = 2;
  localparam int SCALE_W   = 8;
  localparam int QG_W      = 14;
  localparam int BSCALE_W  = 16;

  typedef struct packed {
    logic valid;
    logic last;
  } q6k_ctrl_t;

endpackage

[design/q6k_quantized_dot_product.sv]
// Q6_K dequantize-and-dot-product row accumulator, top level.
// Takes one item (one half-block column: four 6-bit codes, their group scales,
// four activations and the block scale) per clock while in_ready is high.
// Four lanes form (code-32)*scale*act in two multiplier stages; merge
// stages add the lanes, multiply by the block scale and add into a
// saturating accumulator, whose result for an item marked last is registered
// into row_sum. in_ready drops only while a finished row sum waits on
// out_ready and the next row end has reached the accumulator stage.
`include "q6k_quantized_dot_product_assert.svh"

module q6k_quantized_dot_product #(
  parameter int ACT_WIDTH = 16,
  parameter int ACC_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   low_byte_first,
  input  logic [7:0]                   low_byte_second,
  input  logic [7:0]                   high_bits_byte,
  input  logic [4:0]                   column,
  input  logic [63:0]                  group_scales,
  input  logic [15:0]                  block_scale,
  input  logic signed [ACT_WIDTH-1:0]  act_first,
  input  logic signed [ACT_WIDTH-1:0]  act_second,
  input  logic signed [ACT_WIDTH-1:0]  act_third,
  input  logic signed [ACT_WIDTH-1:0]  act_fourth,
  input  logic                         last_in_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ACC_WIDTH-1:0]  row_sum,
  output logic                         saturated
);

  localparam int PROD_W = ACT_WIDTH + q6k_pkg::QG_W;

  logic                                advance;
  q6k_pkg::q6k_ctrl_t                  c1, c2;
  logic [q6k_pkg::BSCALE_W-1:0]        bs1, bs2;
  logic [q6k_pkg::NIB_W-1:0]           lo_nib  [q6k_pkg::LANES];
  logic [q6k_pkg::HIBITS_W-1:0]        hi_bits [q6k_pkg::LANES];
  logic signed [q6k_pkg::SCALE_W-1:0]  scale   [q6k_pkg::LANES];
  logic signed [ACT_WIDTH-1:0]         act     [q6k_pkg::LANES];
  logic signed [PROD_W-1:0]            prod    [q6k_pkg::LANES];

  assign in_ready = advance;

  assign lo_nib[0]  = low_byte_first[3:0];
  assign lo_nib[1]  = low_byte_second[3:0];
  assign lo_nib[2]  = low_byte_first[7:4];
  assign lo_nib[3]  = low_byte_second[7:4];
  assign hi_bits[0] = high_bits_byte[1:0];
  assign hi_bits[1] = high_bits_byte[3:2];
  assign hi_bits[2] = high_bits_byte[5:4];
  assign hi_bits[3] = high_bits_byte[7:6];
  assign act[0]     = act_first;
  assign act[1]     = act_second;
  assign act[2]     = act_third;
  assign act[3]     = act_fourth;

  for (genvar s = 0; s < q6k_pkg::LANES; s++) begin : g_lane
    // upper half of the columns uses the odd scale of each pair
    assign scale[s] = column[4] ? group_scales[16*s+8 +: 8] : group_scales[16*s +: 8];

    q6k_lane #(.ACT_WIDTH(ACT_WIDTH)) u_lane (
      .clk     (clk),
      .advance (advance),
      .lo_nib  (lo_nib[s]),
      .hi_bits (hi_bits[s]),
      .scale   (scale[s]),
      .act     (act[s]),
      .prod    (prod[s])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bs1 <= block_scale;
      bs2 <= bs1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
    end else if (advance) begin
      c1 <= '{valid: in_valid, last: last_in_row};
      c2 <= c1;
    end
  end

  q6k_merge #(.ACT_WIDTH(ACT_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_ctrl   (c2),
    .prod0     (prod[0]),
    .prod1     (prod[1]),
    .prod2     (prod[2]),
    .prod3     (prod[3]),
    .bscale    (bs2),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .row_sum   (row_sum),
    .saturated (saturated),
    .advance   (advance)
  );

  `Q6K_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input stalled with no row waiting")
  `Q6K_ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready, "stall without held row")
  `Q6K_ASSERT_IMP(a_load_on_advance, $rose(out_valid), $past(advance), "row loaded while stalled")
  `Q6K_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(row_sum), "row lost")

endmodule

[design/q6k_lane.sv]
// One lane: 6-bit code decode, group-scale multiply, activation multiply.
module q6k_lane #(
  parameter int ACT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                advance,
  input  logic [q6k_pkg::NIB_W-1:0]           lo_nib,
  input  logic [q6k_pkg::HIBITS_W-1:0]        hi_bits,
  input  logic signed [q6k_pkg::SCALE_W-1:0]  scale,
  input  logic signed [ACT_WIDTH-1:0]         act,
  output logic signed [ACT_WIDTH+q6k_pkg::QG_W-1:0] prod
);

  localparam int QG_W   = q6k_pkg::QG_W;
  localparam int PROD_W = ACT_WIDTH + q6k_pkg::QG_W;

  // code - 32 is the 6-bit code with its top bit flipped
  logic signed [q6k_pkg::NIB_W+q6k_pkg::HIBITS_W-1:0] code_diff;
  logic signed [q6k_pkg::QG_W-1:0]                    qg;
  logic signed [ACT_WIDTH-1:0]                        act_q;

  assign code_diff = {~hi_bits[1], hi_bits[0], lo_nib};

  always_ff @(posedge clk) begin
    if (advance) begin
      qg    <= QG_W'(code_diff) * QG_W'(scale);
      act_q <= act;
      prod  <= PROD_W'(qg) * PROD_W'(act_q);
    end
  end

endmodule

[design/q6k_merge.sv]
// Lane merge: four-way sum, block-scale multiply, saturating row accumulator.
module q6k_merge #(
  parameter int ACT_WIDTH = 16,
  parameter int ACC_WIDTH = 64
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  q6k_pkg::q6k_ctrl_t                         in_ctrl,
  input  logic signed [ACT_WIDTH+q6k_pkg::QG_W-1:0]  prod0,
  input  logic signed [ACT_WIDTH+q6k_pkg::QG_W-1:0]  prod1,
  input  logic signed [ACT_WIDTH+q6k_pkg::QG_W-1:0]  prod2,
  input  logic signed [ACT_WIDTH+q6k_pkg::QG_W-1:0]  prod3,
  input  logic [q6k_pkg::BSCALE_W-1:0]               bscale,
  input  logic                                       out_ready,
  output logic                                       out_valid,
  output logic signed [ACC_WIDTH-1:0]                row_sum,
  output logic                                       saturated,
  output logic                                       advance
);

  localparam int PROD_W = ACT_WIDTH + q6k_pkg::QG_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int TERM_W = DOT_W + q6k_pkg::BSCALE_W + 1;
  localparam int SUM_W  = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;
  localparam logic signed [SUM_W-1:0] ACC_HI =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;

  q6k_pkg::q6k_ctrl_t               c3, c4;
  logic signed [DOT_W-1:0]          dot;
  logic [q6k_pkg::BSCALE_W-1:0]     bs3;
  logic signed [TERM_W-1:0]         term;
  logic signed [ACC_WIDTH-1:0]      acc;
  logic                             ovf;
  logic signed [SUM_W-1:0]          sum_wide;
  logic                             sat_now;
  logic signed [ACC_WIDTH-1:0]      acc_next;
  logic                             ovf_next;
  logic                             take;

  assign advance = !(out_valid && !out_ready && c4.valid && c4.last);
  assign take    = advance && c4.valid;

  always_comb begin
    sum_wide = SUM_W'(acc) + SUM_W'(term);
    sat_now  = 1'b0;
    acc_next = sum_wide[ACC_WIDTH-1:0];
    if (sum_wide > ACC_HI) begin
      acc_next = ACC_HI[ACC_WIDTH-1:0];
      sat_now  = 1'b1;
    end else if (sum_wide < ACC_LO) begin
      acc_next = ACC_LO[ACC_WIDTH-1:0];
      sat_now  = 1'b1;
    end
    ovf_next = ovf || sat_now;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dot  <= DOT_W'(prod0) + DOT_W'(prod1) + DOT_W'(prod2) + DOT_W'(prod3);
      bs3  <= bscale;
      term <= TERM_W'(dot) * TERM_W'($signed({1'b0, bs3}));
    end
    if (take && c4.last) begin
      row_sum   <= acc_next;
      saturated <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3        <= '0;
      c4        <= '0;
      acc       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        c3 <= in_ctrl;
        c4 <= c3;
      end
      if (take) begin
        if (c4.last) begin
          acc <= '0;
          ovf <= 1'b0;
        end else begin
          acc <= acc_next;
          ovf <= ovf_next;
        end
      end
      if (take && c4.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[dv/testbench.sv]
// Self-checking testbench for the Q6_K quantized dot-product row accumulator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RST_CYCLES   = 11;
  localparam int     LIMIT_CYCLES = 4_000_000;
  localparam int     SAT_COLUMNS  = 40;
  localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN      = -ACC_MAX - 1;

  typedef struct {
    logic [7:0]       lb1;
    logic [7:0]       lb2;
    logic [7:0]       hb;
    logic [4:0]       col;
    logic [63:0]      gs;
    logic [15:0]      bs;
    logic [3:0][15:0] acts;
    bit               last;
    bit               drain;
    bit               dense;
  } column_item_t;

  typedef struct {
    longint sum;
    bit     clamped;
  } row_total_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] low_byte_first = '0;
  logic [7:0] low_byte_second = '0;
  logic [7:0] high_bits_byte = '0;
  logic [4:0] column = '0;
  logic [63:0] group_scales = '0;
  logic [15:0] block_scale = '0;
  logic signed [15:0] act_first = '0;
  logic signed [15:0] act_second = '0;
  logic signed [15:0] act_third = '0;
  logic signed [15:0] act_fourth = '0;
  logic last_in_row = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] row_sum;
  logic saturated;

  column_item_t columns_to_send[$];
  row_total_t   row_sums_due[$];
  longint       row_acc = 0;
  bit           row_clamped = 1'b0;
  int           items_taken = 0;
  int           row_ends_taken = 0;
  int           row_sums_seen = 0;
  int           error_count = 0;
  int           total_items = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_pct = 0;
  int           pattern_left = 0;

  q6k_quantized_dot_product dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .low_byte_first(low_byte_first), .low_byte_second(low_byte_second),
    .high_bits_byte(high_bits_byte), .column(column),
    .group_scales(group_scales), .block_scale(block_scale),
    .act_first(act_first), .act_second(act_second),
    .act_third(act_third), .act_fourth(act_fourth),
    .last_in_row(last_in_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_sum(row_sum), .saturated(saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // block_scale * sum over lanes of (code - 32) * group scale * activation
  function automatic longint column_term(column_item_t it);
    logic [5:0] code [4];
    byte        gsc;
    shortint    act;
    longint     dot;
    longint     bsl;
    int         k;
    code[0] = {it.hb[1:0], it.lb1[3:0]};
    code[1] = {it.hb[3:2], it.lb2[3:0]};
    code[2] = {it.hb[5:4], it.lb1[7:4]};
    code[3] = {it.hb[7:6], it.lb2[7:4]};
    dot = 0;
    for (int s = 0; s < 4; s++) begin
      k = 2 * s + it.col[4];
      gsc = it.gs[8*k +: 8];
      act = it.acts[s];
      dot += (longint'(code[s]) - 32) * longint'(gsc) * longint'(act);
    end
    bsl = it.bs;
    return dot * bsl;
  endfunction

  function automatic column_item_t make_item(logic [7:0] lb1, logic [7:0] lb2,
                                             logic [7:0] hb, logic [4:0] col,
                                             logic [63:0] gs, logic [15:0] bs,
                                             logic [15:0] a0, logic [15:0] a1,
                                             logic [15:0] a2, logic [15:0] a3,
                                             bit last);
    column_item_t it;
    it.lb1 = lb1;
    it.lb2 = lb2;
    it.hb = hb;
    it.col = col;
    it.gs = gs;
    it.bs = bs;
    it.acts = {a3, a2, a1, a0};
    it.last = last;
    it.drain = 1'b0;
    it.dense = 1'b0;
    return it;
  endfunction

  function automatic logic [15:0] random_act();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic column_item_t random_item();
    column_item_t it;
    logic [15:0]  bs;
    case ($urandom_range(0, 7))
      0: bs = 16'h0000;
      1: bs = 16'hFFFF;
      default: bs = $urandom;
    endcase
    it = make_item($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom}, bs,
                   random_act(), random_act(), random_act(), random_act(),
                   $urandom_range(0, 9) == 0);
    return it;
  endfunction

  task automatic queue_random(int count);
    column_item_t it;
    bit           row_ended;
    row_ended = 1'b0;
    for (int i = 0; i < count; i++) begin
      it = random_item();
      it.drain = row_ended && $urandom_range(0, 14) == 0;
      row_ended = it.last;
      columns_to_send.push_back(it);
    end
  endtask

  // one long row of full-size terms in one direction, then pushed back the other way
  task automatic queue_saturating_row(logic [15:0] push_act, logic [15:0] back_act);
    column_item_t it;
    for (int i = 0; i < SAT_COLUMNS; i++) begin
      it = make_item(8'h00, 8'h00, 8'h00, $urandom, 64'h8080_8080_8080_8080, 16'hFFFF,
                     push_act, push_act, push_act, push_act, 1'b0);
      it.dense = 1'b1;
      it.drain = (i == 0);
      columns_to_send.push_back(it);
    end
    for (int i = 0; i < 3; i++) begin
      columns_to_send.push_back(make_item(8'h00, 8'h00, 8'h00, $urandom,
                                          64'h8080_8080_8080_8080, 16'hFFFF,
                                          back_act, back_act, back_act, back_act, 1'b0));
    end
    it = random_item();
    it.last = 1'b1;
    columns_to_send.push_back(it);
  endtask

  initial begin
    column_item_t it;
    columns_to_send.push_back(make_item(8'h00, 8'h00, 8'h00, 5'd0, 64'h0, 16'h0000,
                                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    columns_to_send.push_back(make_item(8'hFF, 8'hFF, 8'hFF, 5'd31, '1, 16'hFFFF,
                                        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
    columns_to_send.push_back(make_item(8'h00, 8'h00, 8'h00, 5'd0, 64'h8080_8080_8080_8080,
                                        16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                        1'b0));
    columns_to_send.push_back(make_item(8'h00, 8'h00, 8'h00, 5'd15, 64'h8080_8080_8080_8080,
                                        16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                        1'b0));
    columns_to_send.push_back(make_item(8'hFF, 8'hFF, 8'hFF, 5'd16, 64'h7F7F_7F7F_7F7F_7F7F,
                                        16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                        1'b1));
    // every code equal to the zero point
    columns_to_send.push_back(make_item(8'h00, 8'h00, 8'hAA, 5'd7, '1, 16'hFFFF,
                                        16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1));
    columns_to_send.push_back(make_item(8'hFF, 8'h00, 8'h55, 5'd3, 64'h8080_8080_8080_8080,
                                        16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                        1'b0));
    columns_to_send.push_back(make_item(8'h0F, 8'hF0, 8'hC3, 5'd20, 64'h0102_0408_1020_4080,
                                        16'h0001, 16'h0001, 16'hFFFF, 16'h0100, 16'h7FFF,
                                        1'b1));
    // nibble and scale routing: distinct value per lane and scale index
    columns_to_send.push_back(make_item(8'h5A, 8'hC3, 8'h1B, 5'd15, 64'h0786_0584_0382_0180,
                                        16'h1234, 16'h0011, 16'hFF22, 16'h0333, 16'hF444,
                                        1'b0));
    columns_to_send.push_back(make_item(8'h5A, 8'hC3, 8'h1B, 5'd16, 64'h0786_0584_0382_0180,
                                        16'h1234, 16'h0011, 16'hFF22, 16'h0333, 16'hF444,
                                        1'b1));
    it = make_item(8'hA5, 8'h3C, 8'hE4, 5'd31, 64'hFF01_7F80_00FF_8001, 16'h8000,
                   16'h4000, 16'hC000, 16'h0080, 16'hFF80, 1'b0);
    it.drain = 1'b1;
    columns_to_send.push_back(it);
    columns_to_send.push_back(make_item(8'h96, 8'h69, 8'h27, 5'd0, 64'hFF01_7F80_00FF_8001,
                                        16'h8000, 16'h4000, 16'hC000, 16'h0080, 16'hFF80,
                                        1'b0));
    columns_to_send.push_back(make_item(8'h11, 8'hEE, 8'hD8, 5'd17, 64'h8000_0000_0000_007F,
                                        16'h00FF, 16'h7FFF, 16'h0000, 16'h8000, 16'h0001,
                                        1'b1));
    queue_random(400);
    queue_saturating_row(16'h7FFF, 16'h8000);
    queue_saturating_row(16'h8000, 16'h7FFF);
    queue_random(400);
    it = random_item();
    it.last = 1'b1;
    columns_to_send.push_back(it);
    total_items = columns_to_send.size();

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    while (items_taken != total_items || row_ends_taken != row_sums_seen) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // sender: bursts and gaps, dense items skip the gaps
  always @(posedge clk) begin
    column_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (columns_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left != 0 && !columns_to_send[0].dense) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (columns_to_send[0].drain &&
                   (in_valid || row_ends_taken != row_sums_seen)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = columns_to_send.pop_front();
        in_valid <= 1'b1;
        low_byte_first <= nxt.lb1;
        low_byte_second <= nxt.lb2;
        high_bits_byte <= nxt.hb;
        column <= nxt.col;
        group_scales <= nxt.gs;
        block_scale <= nxt.bs;
        act_first <= nxt.acts[0];
        act_second <= nxt.acts[1];
        act_third <= nxt.acts[2];
        act_fourth <= nxt.acts[3];
        last_in_row <= nxt.last;
        if (!nxt.dense) begin
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall rate is redrawn whenever pattern_left runs out, sometimes zero
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_pct <= 0;
      pattern_left <= 0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left <= $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 25;
          2: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // check row sums first, then fold in the item taken at this edge
  always @(posedge clk) begin
    column_item_t seen;
    row_total_t   want;
    longint       term;
    if (!rst) begin
      if (out_valid && out_ready) begin
        row_sums_seen <= row_sums_seen + 1;
        if (row_sums_due.size() == 0) begin
          $error("row sum %0d with no row end pending", row_sum);
          error_count++;
        end else begin
          want = row_sums_due.pop_front();
          if (row_sum !== want.sum) begin
            $error("row_sum: expected %0d, got %0d", want.sum, row_sum);
            error_count++;
          end
          if (saturated !== want.clamped) begin
            $error("saturated: expected %0b, got %0b", want.clamped, saturated);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen = make_item(low_byte_first, low_byte_second, high_bits_byte, column,
                         group_scales, block_scale, act_first, act_second,
                         act_third, act_fourth, last_in_row);
        term = column_term(seen);
        if (term > 0 && row_acc > ACC_MAX - term) begin
          row_acc = ACC_MAX;
          row_clamped = 1'b1;
        end else if (term < 0 && row_acc < ACC_MIN - term) begin
          row_acc = ACC_MIN;
          row_clamped = 1'b1;
        end else begin
          row_acc = row_acc + term;
        end
        items_taken <= items_taken + 1;
        if (last_in_row) begin
          want.sum = row_acc;
          want.clamped = row_clamped;
          row_sums_due.push_back(want);
          row_acc = 0;
          row_clamped = 1'b0;
          row_ends_taken <= row_ends_taken + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

[files.f]
+incdir+design
design/q6k_pkg.sv
design/q6k_lane.sv
design/q6k_merge.sv
design/q6k_quantized_dot_product.sv
dv/testbench.sv
